FILE: sv/led_matrix_scan_driver_top_assert.svh
// Assertion macros shared by the scan driver RTL.
`ifndef LED_MATRIX_SCAN_DRIVER_TOP_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LMSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scan driver check failed");

// Next-cycle implication, checked out of reset.
`define LMSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scan driver check failed");

`endif

FILE: sv/lmsd_pkg.sv
package lmsd_pkg;

    localparam int ROW_PAIRS = 16;
    localparam int COLUMNS   = 32;

    localparam int HALF_DEPTH = ROW_PAIRS * COLUMNS;
    localparam int HALF_AW    = $clog2(HALF_DEPTH);
    localparam int PASSES     = 2 * ROW_PAIRS + 1;
    localparam int PASS_W     = $clog2(PASSES);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam int COLOR_W    = 3;
    localparam int INDEX_W    = 10;
    localparam int ROW_SEL_W  = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // pass phase codes
    localparam logic [1:0] PH_ADDR  = 2'd0;
    localparam logic [1:0] PH_LOW   = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    typedef struct packed {
        logic                 clk;
        logic                 stb;
        logic                 blank;
        logic                 load;
        logic                 data_pass;
        logic [ROW_SEL_W-1:0] row;
    } tick_ctrl_t;

    // Row addressed by a pass: odd passes carry data for row p/2, even passes
    // blank the row before it, wrapping to the last row.
    function automatic logic [ROW_SEL_W-1:0] row_pins(input logic [PASS_W-1:0] p);
        int r;
        r = int'(p) >> 1;
        if (!p[0]) begin
            r = (r == 0) ? ROW_PAIRS - 1 : r - 1;
        end
        return ROW_SEL_W'(r);
    endfunction

endpackage

FILE: sv/led_matrix_scan_driver_top.sv
// Scan driver for a two-half RGB LED panel. Input beats with s_tuser[0] low
// write one 3-bit pixel into the frame buffer (index row*COLUMNS+col, lower
// half offset by ROW_PAIRS*COLUMNS, indices past the buffer are dropped) and
// give no output beat; beats with s_tuser[0] high are scan ticks and each give
// one pin snapshot. One beat is taken per clock while s_tready is high (not
// during clearing or output back-pressure); a tick's snapshot passes through
// the registered RAM read and the output register. After reset both RAMs are
// zeroed in parallel over ROW_PAIRS*COLUMNS (512) addresses with s_tready low.
// m_tlast is the latch strobe and marks the last beat of every pass.
module led_matrix_scan_driver_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] pixel_index, [12:10] pixel_color, [15:13] zero
    input  logic [lmsd_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] func
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] top_rgb, [5:3] bottom_rgb, [9:6] row_select, [10] shift_clock,
    // [11] output_blank, [15:12] zero
    output logic [lmsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    import lmsd_pkg::*;

    logic [INDEX_W-1:0] in_index;
    logic [COLOR_W-1:0] in_color;
    logic               in_acc;
    logic               tick_acc;
    logic               wr_acc;

    logic               clear_reg;
    logic [HALF_AW-1:0] clear_cnt_reg;

    logic [1:0]           phase_reg, phase_next;
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_SEL_W-1:0] pin_row_reg, pin_row_next;
    tick_ctrl_t           ctrl_next;

    logic                 s1_valid_reg;
    tick_ctrl_t           s1_ctrl_reg;
    logic                 out_free;
    logic                 s1_adv;

    logic                 m_valid_reg;
    logic                 m_clk_reg, m_stb_reg, m_blank_reg;
    logic [ROW_SEL_W-1:0] m_row_reg;
    logic [COLOR_W-1:0]   pin_top_reg, pin_bot_reg;

    logic                 top_we, bot_we, rd_en;
    logic [HALF_AW-1:0]   top_waddr, bot_waddr, rd_addr;
    logic [COLOR_W-1:0]   wr_color;
    logic [COLOR_W-1:0]   top_rdata, bot_rdata;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_color = s_tdata[INDEX_W +: COLOR_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !clear_reg && (!s1_valid_reg || out_free);
    assign in_acc   = s_tvalid && s_tready;
    assign tick_acc = in_acc && s_tuser[0];
    assign wr_acc   = in_acc && !s_tuser[0];

    // Pixel writes are steered to the half that owns the index; clearing
    // zeroes both halves at the same address.
    always_comb begin
        top_we    = 1'b0;
        bot_we    = 1'b0;
        top_waddr = HALF_AW'(in_index);
        bot_waddr = HALF_AW'(int'(in_index) - HALF_DEPTH);
        wr_color  = in_color;
        if (clear_reg) begin
            top_we    = 1'b1;
            bot_we    = 1'b1;
            top_waddr = clear_cnt_reg;
            bot_waddr = clear_cnt_reg;
            wr_color  = '0;
        end else if (wr_acc) begin
            if (int'(in_index) < HALF_DEPTH) begin
                top_we = 1'b1;
            end else if (int'(in_index) < 2 * HALF_DEPTH) begin
                bot_we = 1'b1;
            end
        end
    end

    assign rd_addr  = HALF_AW'(int'(pass_reg >> 1) * COLUMNS + int'(col_reg));
    assign rd_en    = tick_acc && (phase_reg == PH_LOW) && pass_reg[0];

    lmsd_ram #(.WIDTH(COLOR_W), .DEPTH(HALF_DEPTH)) u_top_ram (
        .clk   (aclk),
        .we    (top_we),
        .waddr (top_waddr),
        .wdata (wr_color),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (top_rdata)
    );

    lmsd_ram #(.WIDTH(COLOR_W), .DEPTH(HALF_DEPTH)) u_bot_ram (
        .clk   (aclk),
        .we    (bot_we),
        .waddr (bot_waddr),
        .wdata (wr_color),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (bot_rdata)
    );

    // Scan sequencer: advance one step per accepted tick.
    always_comb begin
        phase_next   = phase_reg;
        pass_next    = pass_reg;
        col_next     = col_reg;
        pin_row_next = pin_row_reg;
        ctrl_next    = '0;
        if (tick_acc) begin
            unique case (phase_reg)
                PH_ADDR: begin
                    pin_row_next    = row_pins(pass_reg);
                    col_next        = '0;
                    phase_next      = PH_LOW;
                    ctrl_next.blank = 1'b1;
                end
                PH_LOW: begin
                    phase_next          = PH_HIGH;
                    ctrl_next.load      = 1'b1;
                    ctrl_next.data_pass = pass_reg[0];
                end
                PH_HIGH: begin
                    ctrl_next.clk = 1'b1;
                    if (int'(col_reg) == COLUMNS - 1) begin
                        col_next   = '0;
                        phase_next = PH_LATCH;
                    end else begin
                        col_next   = col_reg + COL_W'(1);
                        phase_next = PH_LOW;
                    end
                end
                PH_LATCH: begin
                    ctrl_next.stb = 1'b1;
                    pass_next     = (int'(pass_reg) == PASSES - 1) ? '0
                                                                   : pass_reg + PASS_W'(1);
                    col_next      = '0;
                    phase_next    = PH_ADDR;
                end
                default: begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
        ctrl_next.row = pin_row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            phase_reg     <= PH_ADDR;
            pass_reg      <= '0;
            col_reg       <= '0;
            pin_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            pin_top_reg   <= '0;
            pin_bot_reg   <= '0;
        end else begin
            if (clear_reg) begin
                clear_cnt_reg <= clear_cnt_reg + HALF_AW'(1);
                if (int'(clear_cnt_reg) == HALF_DEPTH - 1) begin
                    clear_reg <= 1'b0;
                end
            end
            phase_reg   <= phase_next;
            pass_reg    <= pass_next;
            col_reg     <= col_next;
            pin_row_reg <= pin_row_next;

            if (tick_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                m_valid_reg <= 1'b1;
                if (s1_ctrl_reg.load) begin
                    pin_top_reg <= s1_ctrl_reg.data_pass ? top_rdata : '0;
                    pin_bot_reg <= s1_ctrl_reg.data_pass ? bot_rdata : '0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            s1_ctrl_reg <= ctrl_next;
        end
        if (s1_adv) begin
            m_clk_reg   <= s1_ctrl_reg.clk;
            m_stb_reg   <= s1_ctrl_reg.stb;
            m_blank_reg <= s1_ctrl_reg.blank;
            m_row_reg   <= s1_ctrl_reg.row;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_stb_reg;
    assign m_tdata  = {4'b0, m_blank_reg, m_clk_reg, m_row_reg, pin_bot_reg, pin_top_reg};

    `include "led_matrix_scan_driver_top_assert.svh"

    `LMSD_ASSERT_NOW(a_no_accept_in_clear, clear_reg, !s_tready)
    `LMSD_ASSERT_NOW(a_latch_not_blank, m_tvalid, !(m_tlast && m_tdata[11]))
    `LMSD_ASSERT_NEXT(a_last_col_latches,
        tick_acc && phase_reg == PH_HIGH && int'(col_reg) == COLUMNS - 1,
        phase_reg == PH_LATCH)
    `LMSD_ASSERT_NOW(a_read_only_data_pass, rd_en, pass_reg[0] && !clear_reg)

endmodule

FILE: sv/lmsd_ram.sv
module lmsd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sim/lmsd_pin_checker.sv
package lmsd_tb_pkg;

    // s_tuser[0] codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

endpackage

module lmsd_pin_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    import lmsd_pkg::ROW_PAIRS;
    import lmsd_pkg::COLUMNS;
    import lmsd_pkg::HALF_DEPTH;
    import lmsd_pkg::PASSES;
    import lmsd_pkg::ROW_SEL_W;
    import lmsd_pkg::PH_ADDR;
    import lmsd_pkg::PH_LOW;
    import lmsd_pkg::PH_HIGH;
    import lmsd_tb_pkg::FUNC_TICK;

    localparam int FRAME_DEPTH = 2 * HALF_DEPTH;

    typedef struct packed {
        logic [2:0]           top;
        logic [2:0]           bottom;
        logic [ROW_SEL_W-1:0] row;
        logic                 clk;
        logic                 latch;
        logic                 blank;
    } pin_beat_t;

    logic [2:0]           frame_buf [FRAME_DEPTH];
    int                   pass_no;
    int                   col_no;
    logic [1:0]           scan_phase;
    logic [2:0]           top_pins;
    logic [2:0]           bottom_pins;
    logic [ROW_SEL_W-1:0] row_addr;
    pin_beat_t            pin_q [$];
    pin_beat_t            want;
    pin_beat_t            got;
    int                   wr_idx;

    // Advance the scan sequencer by one tick and return the pin levels it drives.
    function automatic pin_beat_t next_pin_beat();
        pin_beat_t b;
        int        line;
        int        pix_addr;
        b = '0;
        case (scan_phase)
            PH_ADDR: begin
                // even passes blank the row before, row 0 wraps to the last one
                line = pass_no / 2;
                if (pass_no % 2 == 0) line = (line + ROW_PAIRS - 1) % ROW_PAIRS;
                row_addr = ROW_SEL_W'(line);
                b.blank = 1'b1;
                col_no = 0;
                scan_phase = PH_LOW;
            end
            PH_LOW: begin
                if (pass_no % 2 == 1) begin
                    pix_addr = (pass_no / 2) * COLUMNS + col_no;
                    top_pins = frame_buf[pix_addr % FRAME_DEPTH];
                    bottom_pins = frame_buf[(pix_addr + HALF_DEPTH) % FRAME_DEPTH];
                end else begin
                    top_pins = '0;
                    bottom_pins = '0;
                end
                scan_phase = PH_HIGH;
            end
            PH_HIGH: begin
                b.clk = 1'b1;
                col_no++;
                scan_phase = (col_no >= COLUMNS) ? lmsd_pkg::PH_LATCH : PH_LOW;
            end
            default: begin
                b.latch = 1'b1;
                pass_no++;
                if (pass_no >= PASSES) pass_no = 0;
                col_no = 0;
                scan_phase = PH_ADDR;
            end
        endcase
        b.top = top_pins;
        b.bottom = bottom_pins;
        b.row = row_addr;
        return b;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (frame_buf[i]) frame_buf[i] = '0;
            pass_no = 0;
            col_no = 0;
            scan_phase = PH_ADDR;
            top_pins = '0;
            bottom_pins = '0;
            row_addr = '0;
            pin_q.delete();
            errors = 0;
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == FUNC_TICK) begin
                    pin_q.push_back(next_pin_beat());
                end else begin
                    // drop writes past the end of the buffer
                    wr_idx = int'(s_tdata[9:0]);
                    if (wr_idx < FRAME_DEPTH) frame_buf[wr_idx] = s_tdata[12:10];
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{top: m_tdata[2:0], bottom: m_tdata[5:3], row: m_tdata[9:6],
                        clk: m_tdata[10], latch: m_tlast, blank: m_tdata[11]};
                if (pin_q.size() == 0) begin
                    $display("%0t: unexpected pin beat, expected none got %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pin_q.pop_front();
                    check_field("top_rgb", want.top, got.top);
                    check_field("bottom_rgb", want.bottom, got.bottom);
                    check_field("row_select", want.row, got.row);
                    check_field("shift_clock", want.clk, got.clk);
                    check_field("latch_strobe", want.latch, got.latch);
                    check_field("output_blank", want.blank, got.blank);
                end
            end
            pending <= pin_q.size();
        end
    end

endmodule

FILE: sim/tb_led_matrix_scan_driver_top.sv
module tb_led_matrix_scan_driver_top;

    import lmsd_tb_pkg::FUNC_WRITE;
    import lmsd_tb_pkg::FUNC_TICK;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 470;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int errors;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    int idle_sel [4] = '{0, 48, 0, 37};
    int stall_sel [4] = '{0, 0, 48, 37};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    led_matrix_scan_driver_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lmsd_pin_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pin beats outstanding", $time, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one beat, with random gaps ahead of it, and hold until taken.
    task automatic send_beat(input logic func, input logic [9:0] idx, input logic [2:0] color);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {3'b000, color, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_pins();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // corners of both halves, then the start of the first blank pass
        send_beat(FUNC_WRITE, 10'd0, 3'd7);
        send_beat(FUNC_WRITE, 10'd31, 3'd1);
        send_beat(FUNC_WRITE, 10'd511, 3'd4);
        send_beat(FUNC_WRITE, 10'd512, 3'd2);
        send_beat(FUNC_WRITE, 10'd543, 3'd6);
        send_beat(FUNC_WRITE, 10'd1023, 3'd7);
        send_beat(FUNC_WRITE, 10'd1, 3'd3);
        send_beat(FUNC_WRITE, 10'd513, 3'd5);
        repeat (12) send_beat(FUNC_TICK, 10'($urandom), 3'($urandom));

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_sel[ph];
            stall_pct = stall_sel[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mostly ticks so the scan advances through many passes of the frame
                if ($urandom_range(15) == 0) begin
                    send_beat(FUNC_WRITE, 10'($urandom), 3'($urandom));
                end else begin
                    send_beat(FUNC_TICK, 10'($urandom), 3'($urandom));
                end
            end
            if (ph == 0) drain_pins();
        end

        stall_pct = 0;
        drain_pins();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending != 0) $display("%0t: %0d pin beats never arrived", $time, pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/lmsd_pkg.sv
sv/lmsd_ram.sv
sv/led_matrix_scan_driver_top.sv
sim/lmsd_pin_checker.sv
sim/tb_led_matrix_scan_driver_top.sv
